FILE: hdl/smeu_pkg.sv
// Package for the stack machine execute unit: opcodes, error codes,
// controller states and the command/status structs. No dependencies.
package smeu_pkg;

    localparam int WORD_W = 64;

    typedef enum logic [3:0] {
        OP_PUSH = 4'd0,
        OP_POP  = 4'd1,
        OP_SWAP = 4'd2,
        OP_DUP  = 4'd3,
        OP_ADD  = 4'd4,
        OP_SUB  = 4'd5,
        OP_MUL  = 4'd6,
        OP_DIV  = 4'd7,
        OP_CMP  = 4'd8,
        OP_NEG  = 4'd9
    } op_t;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_UNDER = 2'd1,
        ERR_OVER  = 2'd2,
        ERR_DIVZ  = 2'd3
    } err_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_ITER,
        ST_WRITE,
        ST_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture input transaction
        logic rd_b;      // read top entry
        logic rd_a;      // read second entry
        logic exec;      // decide and start
        logic iter;      // one mul/div step
        logic commit;    // write back result and count
        logic out_load;  // load output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic need_iter;  // mul/div started
        logic iter_done;  // last step done
    } stat_t;

endpackage

FILE: hdl/smeu_ctrl.sv
// Controller state machine for the stack machine execute unit.
// Depends on smeu_pkg.
module smeu_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_fire,
    input  logic           out_busy,
    input  smeu_pkg::stat_t stat,
    output logic           in_ready,
    output smeu_pkg::cmd_t cmd
);

    smeu_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= smeu_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            smeu_pkg::ST_IDLE:  if (in_fire) state_next = smeu_pkg::ST_READ;
            smeu_pkg::ST_READ:  state_next = smeu_pkg::ST_EXEC;
            smeu_pkg::ST_EXEC:
                state_next = stat.need_iter ? smeu_pkg::ST_ITER : smeu_pkg::ST_WRITE;
            smeu_pkg::ST_ITER:  if (stat.iter_done) state_next = smeu_pkg::ST_WRITE;
            smeu_pkg::ST_WRITE: state_next = smeu_pkg::ST_OUT;
            smeu_pkg::ST_OUT:   if (!out_busy) state_next = smeu_pkg::ST_IDLE;
            default:            state_next = smeu_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            smeu_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_fire;
                cmd.rd_b = in_fire;
            end
            smeu_pkg::ST_READ:  cmd.rd_a = 1'b1;
            smeu_pkg::ST_EXEC:  cmd.exec = 1'b1;
            smeu_pkg::ST_ITER:  cmd.iter = 1'b1;
            smeu_pkg::ST_WRITE: cmd.commit = 1'b1;
            smeu_pkg::ST_OUT:   cmd.out_load = !out_busy;
            default:            cmd = '0;
        endcase
    end

endmodule

FILE: hdl/smeu_datapath.sv
// Datapath: stack memory, count, operand registers, shared radix-2
// multiply/divide unit, output register. Depends on smeu_pkg.
module smeu_datapath
#(
    parameter int STACK_DEPTH = 64
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  smeu_pkg::cmd_t  cmd,
    output smeu_pkg::stat_t stat,
    input  logic [3:0]      action,
    input  logic [63:0]     push_value,
    input  logic            out_pop,
    output logic            out_busy,
    output logic [79:0]     out_data
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int W  = smeu_pkg::WORD_W;

    logic [63:0] mem [STACK_DEPTH];
    logic [63:0] rd_data_reg;
    logic [CW-1:0] count_reg;
    logic [3:0]  act_reg;
    logic [63:0] pv_reg;
    logic [63:0] b_reg, a_reg;
    logic [1:0]  err_reg;
    logic [63:0] acc_reg, opx_reg, opy_reg;
    logic [6:0]  iter_reg;
    logic        neg_reg;
    logic        valid_out_reg;
    logic [79:0] out_reg;

    // writeback decision
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [63:0]   wr_data;
    logic          wr2_en;
    logic [CW-1:0] cnt_next;

    // second write of swap happens in OUT state through a pending flag
    logic          swap_pend_reg;
    logic [AW-1:0] swap_addr_reg;
    logic [63:0]   swap_data_reg;
    logic          top_out_valid;

    logic [CW-1:0] n;
    assign n = count_reg;
    logic n_ge1, n_ge2, n_full;
    assign n_ge1  = (n != '0);
    assign n_ge2  = (n > CW'(1));
    assign n_full = (n == CW'(STACK_DEPTH));

    logic [CW-1:0] nm1, nm2;
    assign nm1 = n - CW'(1);
    assign nm2 = n - CW'(2);

    // memory read address: top at load, second at read
    logic [AW-1:0] rd_addr;
    assign rd_addr = cmd.rd_a ? nm2[AW-1:0] : nm1[AW-1:0];

    // single write port: commit write, or the swap's second write in the cycle after it
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
        if (wr_en) mem[wr_addr] <= wr_data;
        else if (swap_pend_reg) mem[swap_addr_reg] <= swap_data_reg;
    end

    // signed-magnitude helper for the divisor
    logic [63:0] mag_b;
    assign mag_b = b_reg[63] ? (64'd0 - b_reg) : b_reg;

    // divide step: restoring, one quotient bit per cycle
    logic [64:0] rem_sh;
    logic [64:0] rem_sub;
    assign rem_sh  = {acc_reg, opx_reg[63]};
    assign rem_sub = rem_sh - {1'b0, opy_reg};

    logic [63:0] cmp_res;
    always_comb
    begin
        if ($signed(a_reg) > $signed(b_reg)) cmp_res = 64'd1;
        else if ($signed(a_reg) < $signed(b_reg)) cmp_res = '1;
        else cmp_res = '0;
    end

    assign stat.need_iter = (act_reg == smeu_pkg::OP_MUL || act_reg == smeu_pkg::OP_DIV)
                            && n_ge2 && !(act_reg == smeu_pkg::OP_DIV && b_reg == '0);
    assign stat.iter_done = (iter_reg == 7'(W - 1));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg <= action;
            pv_reg  <= push_value;
        end
        if (cmd.rd_a) b_reg <= rd_data_reg;
        if (cmd.exec)
        begin
            a_reg <= rd_data_reg;
        end
    end

    // a_reg only becomes visible in the cycle after exec: use rd_data for a
    logic [63:0] a_now;
    assign a_now = rd_data_reg;
    logic [63:0] mag_a_now;
    assign mag_a_now = a_now[63] ? (64'd0 - a_now) : a_now;

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            iter_reg <= '0;
            err_reg  <= smeu_pkg::ERR_NONE;
            unique case (act_reg)
                smeu_pkg::OP_PUSH: if (n_full) err_reg <= smeu_pkg::ERR_OVER;
                smeu_pkg::OP_SWAP: if (!n_ge2) err_reg <= smeu_pkg::ERR_UNDER;
                smeu_pkg::OP_DUP:
                    if (!n_ge1) err_reg <= smeu_pkg::ERR_UNDER;
                    else if (n_full) err_reg <= smeu_pkg::ERR_OVER;
                smeu_pkg::OP_ADD, smeu_pkg::OP_SUB, smeu_pkg::OP_CMP,
                smeu_pkg::OP_MUL:
                    if (!n_ge2) err_reg <= smeu_pkg::ERR_UNDER;
                smeu_pkg::OP_DIV:
                    if (!n_ge2) err_reg <= smeu_pkg::ERR_UNDER;
                    else if (b_reg == '0) err_reg <= smeu_pkg::ERR_DIVZ;
                smeu_pkg::OP_NEG: if (!n_ge1) err_reg <= smeu_pkg::ERR_UNDER;
                default: ;
            endcase
            acc_reg <= '0;
            if (act_reg == smeu_pkg::OP_DIV)
            begin
                opx_reg <= mag_a_now;
                opy_reg <= mag_b;
                neg_reg <= a_now[63] ^ b_reg[63];
            end
            else
            begin
                opx_reg <= a_now;
                opy_reg <= b_reg;
                neg_reg <= 1'b0;
            end
        end
        else if (cmd.iter)
        begin
            iter_reg <= iter_reg + 7'd1;
            if (act_reg == smeu_pkg::OP_DIV)
            begin
                opx_reg <= {opx_reg[62:0], !rem_sub[64]};
                acc_reg <= rem_sub[64] ? rem_sh[63:0] : rem_sub[63:0];
            end
            else
            begin
                // shift-add multiply, low 64 bits only
                acc_reg <= acc_reg + (opy_reg[0] ? opx_reg : 64'd0);
                opx_reg <= {opx_reg[62:0], 1'b0};
                opy_reg <= {1'b0, opy_reg[63:1]};
            end
        end
    end

    // final results per operation (a_reg valid from ITER/WRITE on);
    // mul and div both complete after 64 iterations
    logic [63:0] op_res;
    always_comb
    begin
        unique case (act_reg)
            smeu_pkg::OP_ADD: op_res = a_reg + b_reg;
            smeu_pkg::OP_SUB: op_res = a_reg - b_reg;
            smeu_pkg::OP_MUL: op_res = acc_reg;
            smeu_pkg::OP_DIV: op_res = neg_reg ? (64'd0 - opx_reg) : opx_reg;
            smeu_pkg::OP_CMP: op_res = cmp_res;
            default:          op_res = 64'd0 - b_reg;
        endcase
    end

    // commit: memory write and count update
    logic [63:0] top_next;
    always_comb
    begin
        wr_en    = 1'b0;
        wr2_en   = 1'b0;
        wr_addr  = n[AW-1:0];
        wr_data  = pv_reg;
        cnt_next = n;
        top_next = b_reg;
        if (cmd.commit && err_reg == smeu_pkg::ERR_NONE)
        begin
            unique case (act_reg)
                smeu_pkg::OP_PUSH:
                begin
                    wr_en = 1'b1; wr_addr = n[AW-1:0]; wr_data = pv_reg;
                    cnt_next = n + CW'(1); top_next = pv_reg;
                end
                smeu_pkg::OP_POP:
                begin
                    if (n_ge1) cnt_next = nm1;
                    top_next = a_reg;
                end
                smeu_pkg::OP_SWAP:
                begin
                    wr_en = 1'b1; wr_addr = nm1[AW-1:0]; wr_data = a_reg;
                    wr2_en = 1'b1; top_next = a_reg;
                end
                smeu_pkg::OP_DUP:
                begin
                    wr_en = 1'b1; wr_addr = n[AW-1:0]; wr_data = b_reg;
                    cnt_next = n + CW'(1); top_next = b_reg;
                end
                smeu_pkg::OP_ADD, smeu_pkg::OP_SUB, smeu_pkg::OP_MUL,
                smeu_pkg::OP_DIV, smeu_pkg::OP_CMP:
                begin
                    wr_en = 1'b1; wr_addr = nm2[AW-1:0]; wr_data = op_res;
                    cnt_next = nm1; top_next = op_res;
                end
                smeu_pkg::OP_NEG:
                begin
                    wr_en = 1'b1; wr_addr = nm1[AW-1:0]; wr_data = op_res;
                    top_next = op_res;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            swap_pend_reg <= 1'b0;
            valid_out_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit) count_reg <= cnt_next;
            swap_pend_reg <= wr2_en;
            if (cmd.out_load) valid_out_reg <= 1'b1;
            else if (out_pop) valid_out_reg <= 1'b0;
        end
    end

    // top word held after commit for the result
    logic [63:0] top_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.commit) top_reg <= top_next;
        if (wr2_en)
        begin
            swap_addr_reg <= nm2[AW-1:0];
            swap_data_reg <= b_reg;
        end
    end

    assign top_out_valid = (count_reg != '0);

    // pop exposes the new top, which is a_reg (second entry)
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_reg[63:0]  <= top_out_valid ? (err_reg == smeu_pkg::ERR_NONE ||
                              act_reg == smeu_pkg::OP_POP ? top_reg : b_reg) : 64'd0;
            out_reg[64]    <= top_out_valid;
            out_reg[71:65] <= 7'(count_reg);
            out_reg[73:72] <= err_reg;
            out_reg[79:74] <= '0;
        end
    end

    assign out_busy = valid_out_reg && !out_pop;
    assign out_data = out_reg;

endmodule

FILE: hdl/stack_machine_execute_unit.sv
// Top level of the stack machine execute unit: streaming ports, controller
// and datapath. Depends on smeu_pkg, smeu_ctrl, smeu_datapath.
//
// One instruction per input transaction; one result transaction each. Push,
// pop, swap, dup, add, sub, cmp and neg go through the stack memory read of
// two entries, execute, write back and output load, after which m_tvalid
// rises; the next input is not accepted before the output load. Mul and
// div, unless they fail, add 64 steps of a shared one-bit-per-cycle shift
// unit between execute and write back. The next instruction is accepted
// while the previous result still waits in the output register; it then
// holds in its output step, and the input stays closed, until that result
// is taken.
module stack_machine_execute_unit
#(
    parameter int STACK_DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // [3:0] action, [67:4] push_value, zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata    // [63:0] top_value, [64] top_valid,
                                   // [71:65] stack_depth, [73:72] error_code
);

    smeu_pkg::cmd_t  cmd;
    smeu_pkg::stat_t stat;
    logic            out_busy;
    logic            in_fire;
    logic            out_pop;

    assign in_fire = s_tvalid && s_tready;
    assign out_pop = m_tvalid && m_tready;

    smeu_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_busy (out_busy),
        .stat     (stat),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    smeu_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .action     (s_tdata[3:0]),
        .push_value (s_tdata[67:4]),
        .out_pop    (out_pop),
        .out_busy   (out_busy),
        .out_data   (m_tdata)
    );

    logic m_valid_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (out_pop)
        begin
            m_valid_reg <= 1'b0;
        end
    end
    assign m_tvalid = m_valid_reg;

endmodule

FILE: dv/smeu_checker.sv
// Result checker for the stack machine execute unit: watches both streams,
// keeps its own stack, predicts each result and compares. Depends on smeu_pkg.
module smeu_checker
#(
    parameter int STACK_DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [79:0] m_tdata,
    output int          fail_count,
    output int          pending_count,
    output int          result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [63:0]      top_value;
        logic             top_valid;
        logic [6:0]       stack_depth;
        smeu_pkg::err_t   error_code;
    } status_t;

    logic [63:0] word_stack [STACK_DEPTH];
    int          word_count;
    status_t     status_q [$];

    assign pending_count = status_q.size();

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
        fail_count++;
    endtask

    // signed division truncating toward zero, min / -1 wraps
    function automatic logic [63:0] quotient(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] q;
        ma = a[63] ? -a : a;
        mb = b[63] ? -b : b;
        q  = ma / mb;
        return (a[63] != b[63]) ? -q : q;
    endfunction

    // execute one instruction on the local stack, return the status it produces
    function automatic status_t execute(input logic [3:0] action, input logic [63:0] pv);
        status_t        s;
        smeu_pkg::err_t err;
        logic [63:0]    a;
        logic [63:0]    b;
        logic [63:0]    r;
        int             n;
        err = smeu_pkg::ERR_NONE;
        n   = word_count;
        case (action)
            smeu_pkg::OP_PUSH:
                if (n >= STACK_DEPTH) err = smeu_pkg::ERR_OVER;
                else
                begin
                    word_stack[n] = pv;
                    word_count = n + 1;
                end
            smeu_pkg::OP_POP:
                if (n > 0) word_count = n - 1;
            smeu_pkg::OP_SWAP:
                if (n < 2) err = smeu_pkg::ERR_UNDER;
                else
                begin
                    a = word_stack[n-1];
                    word_stack[n-1] = word_stack[n-2];
                    word_stack[n-2] = a;
                end
            smeu_pkg::OP_DUP:
                if (n < 1) err = smeu_pkg::ERR_UNDER;
                else if (n >= STACK_DEPTH) err = smeu_pkg::ERR_OVER;
                else
                begin
                    word_stack[n] = word_stack[n-1];
                    word_count = n + 1;
                end
            smeu_pkg::OP_ADD, smeu_pkg::OP_SUB, smeu_pkg::OP_MUL,
            smeu_pkg::OP_DIV, smeu_pkg::OP_CMP:
                if (n < 2) err = smeu_pkg::ERR_UNDER;
                else
                begin
                    a = word_stack[n-2];
                    b = word_stack[n-1];
                    case (action)
                        smeu_pkg::OP_ADD: r = a + b;
                        smeu_pkg::OP_SUB: r = a - b;
                        smeu_pkg::OP_MUL: r = a * b;
                        smeu_pkg::OP_DIV: r = (b == '0) ? 64'd0 : quotient(a, b);
                        default: r = ($signed(a) > $signed(b)) ? 64'd1 :
                                     ($signed(a) < $signed(b)) ? '1 : 64'd0;
                    endcase
                    if (action == smeu_pkg::OP_DIV && b == '0) err = smeu_pkg::ERR_DIVZ;
                    else
                    begin
                        word_stack[n-2] = r;
                        word_count = n - 1;
                    end
                end
            smeu_pkg::OP_NEG:
                if (n < 1) err = smeu_pkg::ERR_UNDER;
                else word_stack[n-1] = -word_stack[n-1];
            default: ;
        endcase
        n = word_count;
        s.top_value   = (n > 0) ? word_stack[n-1] : 64'd0;
        s.top_valid   = (n > 0);
        s.stack_depth = n[6:0];
        s.error_code  = err;
        return s;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        status_t want;
        if (!rst_n)
        begin
            word_count   = 0;
            fail_count   = 0;
            result_count = 0;
            status_q.delete();
        end
        else
        begin
            // predict on each accepted instruction
            if (s_tvalid && s_tready)
                status_q.push_back(execute(s_tdata[3:0], s_tdata[67:4]));
            // compare each accepted result with the oldest prediction
            if (m_tvalid && m_tready)
            begin
                result_count++;
                if (status_q.size() == 0)
                    report("unexpected result", m_tdata[63:0], 64'd0);
                else
                begin
                    want = status_q.pop_front();
                    if (m_tdata[63:0] !== want.top_value)
                        report("top_value", m_tdata[63:0], want.top_value);
                    if (m_tdata[64] !== want.top_valid)
                        report("top_valid", 64'(m_tdata[64]), 64'(want.top_valid));
                    if (m_tdata[71:65] !== want.stack_depth)
                        report("stack_depth", 64'(m_tdata[71:65]), 64'(want.stack_depth));
                    if (m_tdata[73:72] !== want.error_code)
                        report("error_code", 64'(m_tdata[73:72]), 64'(want.error_code));
                end
            end
        end
    end
endmodule

FILE: dv/tb.sv
// Testbench top for the stack machine execute unit: clock, reset, directed
// and random instruction streams, verdict. Depends on smeu_pkg, smeu_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 64;
    localparam logic [63:0] MIN_WORD = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAX_WORD = 64'h7FFF_FFFF_FFFF_FFFF;
    // action codes with no instruction behind them
    localparam logic [3:0] ACT_SPARE_LO = 4'd12;
    localparam logic [3:0] ACT_SPARE_HI = 4'd15;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;
    int          fail_count;
    int          pending_count;
    int          result_count;
    bit          steady;   // no idling on either side while set
    int          model_depth;
    int          op_seen [16];

    stack_machine_execute_unit #(.STACK_DEPTH(DEPTH)) uut (.*);

    smeu_checker #(.STACK_DEPTH(DEPTH)) chk (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // result side stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) m_tready <= 1'b0;
        else m_tready <= steady || ($urandom_range(99) >= 16);
    end

    // send one instruction, with an optional idle gap first; valid stays up
    // on return so the next instruction can follow back to back
    task automatic send(input logic [3:0] action, input logic [63:0] pv);
        while (!steady && $urandom_range(99) < 16)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, pv, action};
        op_seen[action]++;
        // track depth so well-formed sequences stay in range
        case (action)
            smeu_pkg::OP_PUSH, smeu_pkg::OP_DUP: if (model_depth < DEPTH) model_depth++;
            smeu_pkg::OP_POP: if (model_depth > 0) model_depth--;
            smeu_pkg::OP_ADD, smeu_pkg::OP_SUB, smeu_pkg::OP_MUL,
            smeu_pkg::OP_DIV, smeu_pkg::OP_CMP: if (model_depth >= 2) model_depth--;
            default: ;
        endcase
        do @(posedge clk); while (!s_tready);
    endtask

    function automatic logic [63:0] rand_word();
        case ($urandom_range(5))
            0: return {$urandom, $urandom};
            1: return MIN_WORD;
            2: return MAX_WORD;
            3: return 64'(signed'($urandom_range(6)) - 3);
            default: return {{32{1'b0}}, $urandom} ^ ({64{$urandom_range(1) == 1}});
        endcase
    endfunction

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (pending_count != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    initial
    begin
        int action;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        rst_n    = 1'b0;
        steady   = 1'b0;
        model_depth = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: underflows on empty stack, then extremes and each operation
        send(smeu_pkg::OP_POP, '1);
        send(smeu_pkg::OP_SWAP, '0);
        send(smeu_pkg::OP_DUP, '0);
        send(smeu_pkg::OP_NEG, '0);
        send(smeu_pkg::OP_ADD, '0);
        send(ACT_SPARE_LO, '1);
        send(smeu_pkg::OP_PUSH, MIN_WORD);
        send(smeu_pkg::OP_NEG, '0);
        send(smeu_pkg::OP_PUSH, '1);
        send(smeu_pkg::OP_DIV, '0);           // min / -1
        send(smeu_pkg::OP_PUSH, '0);
        send(smeu_pkg::OP_DIV, '0);           // divide by zero
        send(smeu_pkg::OP_PUSH, MAX_WORD);
        send(smeu_pkg::OP_MUL, '0);
        send(smeu_pkg::OP_PUSH, 64'd7);
        send(smeu_pkg::OP_PUSH, -64'sd2);
        send(smeu_pkg::OP_DIV, '0);           // truncates toward zero
        send(smeu_pkg::OP_PUSH, 64'd1);
        send(smeu_pkg::OP_CMP, '0);
        send(smeu_pkg::OP_PUSH, MAX_WORD);
        send(smeu_pkg::OP_SWAP, '0);
        send(smeu_pkg::OP_SUB, '0);
        send(ACT_SPARE_HI, '0);
        wait_drain();              // sender holds off until all results are in

        // fill to full, overflow on push and dup, then empty again
        steady = 1'b1;
        while (model_depth < DEPTH) send(smeu_pkg::OP_DUP, '0);
        send(smeu_pkg::OP_PUSH, rand_word());
        send(smeu_pkg::OP_DUP, '0);
        steady = 1'b0;
        while (model_depth > 0) send(smeu_pkg::OP_POP, '0);

        // random: mostly operations the current depth supports, some noise
        for (int i = 0; i < 900; i++)
        begin
            if (i == 300) steady = 1'b1;
            if (i == 450) steady = 1'b0;
            if ($urandom_range(9) == 0) action = $urandom_range(15);
            else if (model_depth < 2 || ($urandom_range(3) == 0 && model_depth < DEPTH))
                action = smeu_pkg::OP_PUSH;
            else action = $urandom_range(smeu_pkg::OP_NEG, smeu_pkg::OP_POP);
            send(4'(action), rand_word());
        end
        wait_drain();

        $display("covered %0d results: push %0d mul %0d div %0d cmp %0d,",
                 result_count, op_seen[smeu_pkg::OP_PUSH], op_seen[smeu_pkg::OP_MUL],
                 op_seen[smeu_pkg::OP_DIV], op_seen[smeu_pkg::OP_CMP]);
        $display("with underflow, overflow at a full stack and divide by zero");
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // worst case: ~1050 items plus stalls, taken several times over
    initial
    begin
        #8ms;
        $display("TEST FAILED");
        $finish;
    end
endmodule

FILE: sim.f
hdl/smeu_pkg.sv
hdl/smeu_ctrl.sv
hdl/smeu_datapath.sv
hdl/stack_machine_execute_unit.sv
dv/smeu_checker.sv
dv/tb.sv
